/* src/slcfr_pkg.sv */
// ============================================================================
// slcfr_pkg: shared types and constants of the frame receiver
// Event codes, front-to-back token format, CSR layout and the CRC-16 step.
// ============================================================================
package slcfr_pkg;

   // Largest body (payload plus two CRC bytes) the receiver takes
   localparam int unsigned MAX_BODY = 1030;
   localparam logic [15:0] MAX_BODY_LEN = 16'(MAX_BODY);
   localparam logic [15:0] MIN_BODY_LEN = 16'd2;
   localparam logic [10:0] CRC_BYTES = 11'd2;

   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [7:0] HDR_INVERT = 8'hFF;

   // CSR reset values
   localparam logic [7:0] START_BYTE_RESET = 8'h02;
   localparam logic [15:0] CRC_INIT_RESET = 16'hFFFF;

   // CSR indexes (byte address 4*i, decoded on paddr[2])
   localparam logic CSR_IDX_START_BYTE = 1'b0;
   localparam logic CSR_IDX_CRC_INIT = 1'b1;

   // Token queue depth
   localparam int unsigned QUEUE_DEPTH = 2;

   typedef enum logic [2:0] {
      EV_NONE = 3'd0,
      EV_PAYLOAD = 3'd1,
      EV_GOOD = 3'd2,
      EV_HDR_ERR = 3'd3,
      EV_CRC_ERR = 3'd4,
      EV_LEN_ERR = 3'd5
   } event_type;

   // What the front end decided about a byte
   typedef enum logic [2:0] {
      TK_NONE = 3'd0,
      TK_START = 3'd1,
      TK_PAYLOAD = 3'd2,
      TK_CRC_LO = 3'd3,
      TK_CRC_HI = 3'd4,
      TK_HDR_ERR = 3'd5,
      TK_LEN_ERR = 3'd6
   } token_kind_type;

   typedef struct packed {
      token_kind_type kind;
      logic [7:0] data;
      logic [10:0] length;
   } token_type;

   typedef enum logic [2:0] {
      PH_HUNT = 3'b001,
      PH_HEADER = 3'b010,
      PH_BODY = 3'b100
   } phase_type;

   typedef struct packed {
      logic [7:0] start_byte;
      logic [15:0] crc_init;
   } csr_type;

   // CRC-16 CCITT, MSB first, one byte
   function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

/* src/stx_length_crc_frame_receiver.sv */
// ============================================================================
// stx_length_crc_frame_receiver: start/length/complement/CRC-16 deframer
// Byte-stream frame receiver: parser front end, token queue, CRC back end.
// ============================================================================
// Path: an accepted req beat goes into a queue entry, then into the registered
//   result stage, and leaves as its rsp beat; rsp_tready stalls hold it there.
// Throughput: one byte per cycle; the one-byte CRC step is unrolled in the
//   back end; while a result waits the queue takes two beats, then req stalls.
// Reset: synchronous, active high; parser returns to hunting, queue empties,
//   CSRs take start byte 0x02 and CRC init 0xFFFF. No clearing pass.
module stx_length_crc_frame_receiver (
   input  logic         clock,
   input  logic         reset,
   // input byte stream
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] data_byte
   // result stream
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [23:0]  rsp_tdata,   // [2:0] event_res, [10:3] payload_byte,
                                     // [21:11] payload_length, [23:22] zero
   // CSR port: 0x0 start_byte, 0x4 crc_init
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   slcfr_pkg::csr_type csr;
   slcfr_pkg::token_type front_tok;
   slcfr_pkg::token_type back_tok;
   logic q_full;
   logic q_not_empty;
   logic q_pop;
   logic req_beat;

   // a byte is taken whenever the queue has room
   assign req_tready = ~q_full;
   assign req_beat = req_tvalid & req_tready;

   slcfr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .csr         (csr)
   );

   // front end: hunt / header / body tagging, one token per accepted beat
   slcfr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_beat),
      .data_byte  (req_tdata),
      .start_byte (csr.start_byte),
      .token      (front_tok)
   );

   slcfr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_beat),
      .push_token (front_tok),
      .pop        (q_pop),
      .full       (q_full),
      .not_empty  (q_not_empty),
      .pop_token  (back_tok)
   );

   // back end: CRC accumulate and check, result register
   slcfr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .tok_valid  (q_not_empty),
      .tok        (back_tok),
      .tok_pop    (q_pop),
      .crc_init   (csr.crc_init),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

/* src/slcfr_csr.sv */
// ============================================================================
// slcfr_csr: configuration registers
// APB-style write/read of start byte and CRC init value.
// ============================================================================
module slcfr_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [2:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready,
   output slcfr_pkg::csr_type   csr
);

   logic [7:0] start_byte_ff;
   logic [15:0] crc_init_ff;
   logic wr_en;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff <= slcfr_pkg::START_BYTE_RESET;
         crc_init_ff <= slcfr_pkg::CRC_INIT_RESET;
      end else if (wr_en) begin
         if (csr_paddr[2] == slcfr_pkg::CSR_IDX_START_BYTE) begin
            start_byte_ff <= csr_pwdata[7:0];
         end else begin
            crc_init_ff <= csr_pwdata[15:0];
         end
      end
   end

   always_comb begin
      if (csr_paddr[2] == slcfr_pkg::CSR_IDX_CRC_INIT) begin
         csr_prdata = {16'h0000, crc_init_ff};
      end else begin
         csr_prdata = {24'h000000, start_byte_ff};
      end
   end

   assign csr.start_byte = start_byte_ff;
   assign csr.crc_init = crc_init_ff;

endmodule

/* src/slcfr_front.sv */
// ============================================================================
// slcfr_front: frame parser
// Hunts for the start byte, checks the header and tags each body byte.
// ============================================================================
module slcfr_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [7:0]            data_byte,
   input  logic [7:0]            start_byte,
   output slcfr_pkg::token_type  token
);

   slcfr_pkg::phase_type phase_ff, phase_in;
   logic [10:0] count_ff, count_in;
   logic [7:0] hdr0_ff, hdr0_in;
   logic [7:0] hdr1_ff, hdr1_in;
   logic hdr_bad_ff, hdr_bad_in;
   logic [10:0] body_len_ff, body_len_in;
   logic [10:0] pay_len;
   logic [15:0] hdr_len;

   assign pay_len = body_len_ff - slcfr_pkg::CRC_BYTES;
   assign hdr_len = {hdr1_ff, hdr0_ff};

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      hdr0_in = hdr0_ff;
      hdr1_in = hdr1_ff;
      hdr_bad_in = hdr_bad_ff;
      body_len_in = body_len_ff;
      token.kind = slcfr_pkg::TK_NONE;
      token.data = data_byte;
      token.length = pay_len;
      case (phase_ff)
         slcfr_pkg::PH_HEADER: begin
            case (count_ff[1:0])
               2'd0: begin
                  hdr0_in = data_byte;
                  count_in = 11'd1;
               end
               2'd1: begin
                  hdr1_in = data_byte;
                  count_in = 11'd2;
               end
               2'd2: begin
                  hdr_bad_in = (data_byte != (hdr0_ff ^ slcfr_pkg::HDR_INVERT));
                  count_in = 11'd3;
               end
               default: begin
                  if (hdr_bad_ff || (data_byte != (hdr1_ff ^ slcfr_pkg::HDR_INVERT))) begin
                     token.kind = slcfr_pkg::TK_HDR_ERR;
                     phase_in = slcfr_pkg::PH_HUNT;
                  end else if ((hdr_len < slcfr_pkg::MIN_BODY_LEN) ||
                               (hdr_len > slcfr_pkg::MAX_BODY_LEN)) begin
                     token.kind = slcfr_pkg::TK_LEN_ERR;
                     phase_in = slcfr_pkg::PH_HUNT;
                  end else begin
                     token.kind = slcfr_pkg::TK_START;
                     body_len_in = hdr_len[10:0];
                     phase_in = slcfr_pkg::PH_BODY;
                  end
                  count_in = '0;
                  hdr_bad_in = 1'b0;
               end
            endcase
         end
         slcfr_pkg::PH_BODY: begin
            if (count_ff < pay_len) begin
               token.kind = slcfr_pkg::TK_PAYLOAD;
               count_in = count_ff + 11'd1;
            end else if (count_ff == pay_len) begin
               token.kind = slcfr_pkg::TK_CRC_LO;
               count_in = count_ff + 11'd1;
            end else begin
               token.kind = slcfr_pkg::TK_CRC_HI;
               phase_in = slcfr_pkg::PH_HUNT;
               count_in = '0;
            end
         end
         default: begin
            phase_in = slcfr_pkg::PH_HUNT;
            count_in = '0;
            if (data_byte == start_byte) begin
               phase_in = slcfr_pkg::PH_HEADER;
               hdr_bad_in = 1'b0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= slcfr_pkg::PH_HUNT;
         count_ff <= '0;
         hdr0_ff <= '0;
         hdr1_ff <= '0;
         hdr_bad_ff <= 1'b0;
         body_len_ff <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         hdr0_ff <= hdr0_in;
         hdr1_ff <= hdr1_in;
         hdr_bad_ff <= hdr_bad_in;
         body_len_ff <= body_len_in;
      end
   end

`ifndef SYNTHESIS
   // body counter never runs past the high CRC byte
   a_body_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == slcfr_pkg::PH_BODY) |-> (count_ff < body_len_ff))
      else $error("body byte count overran body length");
`endif

endmodule

/* src/slcfr_queue.sv */
// ============================================================================
// slcfr_queue: token queue
// Two-entry FIFO between parser and CRC/result stage.
// ============================================================================
module slcfr_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  slcfr_pkg::token_type  push_token,
   input  logic                  pop,
   output logic                  full,
   output logic                  not_empty,
   output slcfr_pkg::token_type  pop_token
);

   slcfr_pkg::token_type entry_ff [slcfr_pkg::QUEUE_DEPTH];
   logic wr_ptr_ff, wr_ptr_in;
   logic rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full = (count_ff == 2'(slcfr_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != 2'd0);
   assign pop_token = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_token;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'(slcfr_pkg::QUEUE_DEPTH))
      else $error("token queue count out of range");
   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      ((count_ff == 2'd0) || full) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("token queue pointers disagree with count");
`endif

endmodule

/* src/slcfr_back.sv */
// ============================================================================
// slcfr_back: CRC and result stage
// Runs the CRC over payload tokens and forms the registered result beat.
// ============================================================================
module slcfr_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  tok_valid,
   input  slcfr_pkg::token_type  tok,
   output logic                  tok_pop,
   input  logic [15:0]           crc_init,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [23:0]           rsp_tdata
);

   logic valid_ff, valid_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0] crc_lo_ff, crc_lo_in;
   slcfr_pkg::event_type event_ff, event_in;
   logic [7:0] pbyte_ff, pbyte_in;
   logic [10:0] plen_ff, plen_in;

   assign tok_pop = tok_valid & (~valid_ff | rsp_tready);

   always_comb begin
      valid_in = valid_ff & ~rsp_tready;
      crc_in = crc_ff;
      crc_lo_in = crc_lo_ff;
      event_in = event_ff;
      pbyte_in = pbyte_ff;
      plen_in = plen_ff;
      if (tok_pop) begin
         valid_in = 1'b1;
         event_in = slcfr_pkg::EV_NONE;
         pbyte_in = '0;
         plen_in = '0;
         case (tok.kind)
            slcfr_pkg::TK_START: crc_in = crc_init;
            slcfr_pkg::TK_PAYLOAD: begin
               crc_in = slcfr_pkg::crc_update(crc_ff, tok.data);
               event_in = slcfr_pkg::EV_PAYLOAD;
               pbyte_in = tok.data;
            end
            slcfr_pkg::TK_CRC_LO: crc_lo_in = tok.data;
            slcfr_pkg::TK_CRC_HI: begin
               if ({tok.data, crc_lo_ff} == crc_ff) begin
                  event_in = slcfr_pkg::EV_GOOD;
                  plen_in = tok.length;
               end else begin
                  event_in = slcfr_pkg::EV_CRC_ERR;
               end
            end
            slcfr_pkg::TK_HDR_ERR: event_in = slcfr_pkg::EV_HDR_ERR;
            slcfr_pkg::TK_LEN_ERR: event_in = slcfr_pkg::EV_LEN_ERR;
            default: event_in = slcfr_pkg::EV_NONE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         crc_ff <= slcfr_pkg::CRC_INIT_RESET;
         crc_lo_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         crc_ff <= crc_in;
         crc_lo_ff <= crc_lo_in;
      end
   end

   always_ff @(posedge clock) begin
      event_ff <= event_in;
      pbyte_ff <= pbyte_in;
      plen_ff <= plen_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata = {2'b00, plen_ff, pbyte_ff, event_ff};

`ifndef SYNTHESIS
   a_crc_load: assert property (@(posedge clock) disable iff (reset)
      (tok_pop && (tok.kind == slcfr_pkg::TK_START)) |=> (crc_ff == $past(crc_init)))
      else $error("CRC not loaded at frame start");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !rsp_tready) |=> ($stable(event_ff) && $stable(plen_ff)))
      else $error("pending result overwritten");
`endif

endmodule
